// File: design/lbm_pkg.sv
// ----------------------------------------------------------------------------
// lbm_pkg - shared types and arithmetic helpers
// Payload structs, register codes, D2Q9 direction tables and the saturating
// fixed-point helpers used across the collision pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lbm_pkg;

  localparam int NUM_DIR  = 9;
  localparam int IO_WIDTH = 32;

  typedef logic signed [IO_WIDTH-1:0] io_word_t;
  typedef logic signed [63:0]         wide_t;
  typedef logic signed [65:0]         ext_t;

  typedef enum logic [7:0] {
    CFG_RELAX_EVEN    = 8'd0,
    CFG_RELAX_ODD     = 8'd1,
    CFG_FORCE_COEFF   = 8'd2,
    CFG_LATTICE_SPEED = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    io_word_t dist_rest;
    io_word_t dist_east;
    io_word_t dist_north;
    io_word_t dist_west;
    io_word_t dist_south;
    io_word_t dist_northeast;
    io_word_t dist_northwest;
    io_word_t dist_southwest;
    io_word_t dist_southeast;
  } dist_t;

  typedef struct packed {
    io_word_t post_rest;
    io_word_t post_east;
    io_word_t post_north;
    io_word_t post_west;
    io_word_t post_south;
    io_word_t post_northeast;
    io_word_t post_northwest;
    io_word_t post_southwest;
    io_word_t post_southeast;
    io_word_t density;
    io_word_t vel_x;
    io_word_t vel_y;
  } result_t;

  localparam int DIR_X   [NUM_DIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y   [NUM_DIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam int DIR_OPP [NUM_DIR] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};

  // clamp to a signed word of w bits
  function automatic wide_t sat_to(ext_t x, int unsigned w);
    ext_t hi;
    ext_t lo;
    hi = (66'sd1 <<< (w - 1)) - 66'sd1;
    lo = -hi - 66'sd1;
    if (x > hi) begin
      return hi[63:0];
    end else if (x < lo) begin
      return lo[63:0];
    end
    return x[63:0];
  endfunction

  function automatic wide_t sadd(wide_t a, wide_t b, int unsigned w);
    return sat_to(66'(a) + 66'(b), w);
  endfunction

  function automatic wide_t ssub(wide_t a, wide_t b, int unsigned w);
    return sat_to(66'(a) - 66'(b), w);
  endfunction

  // halve, rounding toward zero
  function automatic wide_t half_tz(wide_t a);
    wide_t v;
    v = a;
    if (v < 0) begin
      v = v + 64'sd1;
    end
    return v >>> 1;
  endfunction

  // k*a/2 rounded toward zero, saturated
  function automatic wide_t scale_half(wide_t a, int k, int unsigned w);
    ext_t v;
    v = 66'(a) * 66'(k);
    if (v < 0) begin
      v = v + 66'sd1;
    end
    return sat_to(v >>> 1, w);
  endfunction

endpackage

`default_nettype wire

// File: design/lbm_d2q9_trt_collision.sv
// ----------------------------------------------------------------------------
// lbm_d2q9_trt_collision - D2Q9 two-relaxation-time collision, one cell
// Fixed-point TRT collision with constant x body force.
// ----------------------------------------------------------------------------
// Takes one cell (nine distributions) per clock while the output is not
// stalled, and returns its nine post-collision values with density and
// velocity, fully pipelined. The velocity divider resolves one quotient
// bit per pipeline stage; nine direction lanes then run side by side. A
// stalled output holds the whole pipeline. Register writes are taken every
// cycle and must only be made while the block is idle.
`default_nettype none

module lbm_d2q9_trt_collision #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lbm_pkg::dist_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lbm_pkg::result_t  out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);
  import lbm_pkg::*;

  localparam int W        = DATA_WIDTH;
  localparam int F        = FRAC_BITS;
  localparam int DIV_LAT  = W + 3;
  localparam int LANE_LAT = 10;
  localparam int FDLY     = 2 + DIV_LAT;
  localparam int NST      = 3 + DIV_LAT + LANE_LAT;

  localparam logic signed [W-1:0] RST_EVEN  = W'(sat_to(66'(-32'sd16777216), W));
  localparam logic signed [W-1:0] RST_ODD   = W'(sat_to(66'(-32'sd19173961), W));
  localparam logic signed [W-1:0] RST_SPEED = W'(sat_to(66'(32'sd16777216), W));

  logic signed [W-1:0] relax_even_q, relax_odd_q, force_q, speed_q;
  logic signed [W-1:0] cfg_word;

  logic           en;
  logic [NST-1:0] vld_q;
  logic           out_valid_q;
  result_t        out_data_q;

  io_word_t                     in_word [NUM_DIR];
  logic [NUM_DIR-1:0][W-1:0]    f_q;
  logic [NUM_DIR-1:0][W-1:0]    fdl_q [FDLY];
  logic signed [W-1:0]          rdl_q [DIV_LAT];
  logic signed [W-1:0]          rout_q [LANE_LAT];
  logic signed [W-1:0]          velx_dl_q [LANE_LAT-1];
  logic signed [W-1:0]          vely_dl_q [LANE_LAT-1];

  logic signed [W-1:0] rho_m, mx_m, my_m;
  logic signed [W-1:0] vx, vy, velx, vely, vx2, vy2, uv_q;
  logic signed [W-1:0] feq  [NUM_DIR];
  logic signed [W-1:0] post [NUM_DIR];

  // ---- configuration ------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign cfg_word    = W'(sat_to(66'($signed(cfg_data_i)), W));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_even_q <= RST_EVEN;
      relax_odd_q  <= RST_ODD;
      force_q      <= '0;
      speed_q      <= RST_SPEED;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RELAX_EVEN:    relax_even_q <= cfg_word;
        CFG_RELAX_ODD:     relax_odd_q  <= cfg_word;
        CFG_FORCE_COEFF:   force_q      <= cfg_word;
        CFG_LATTICE_SPEED: speed_q      <= cfg_word;
        default: ;
      endcase
    end
  end

  // ---- flow control: whole pipeline moves together -----------------------
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NST-2:0], in_valid_i};
      out_valid_q <= vld_q[NST-1];
    end
  end

  // ---- input stage --------------------------------------------------------
  assign in_word[0] = in_data_i.dist_rest;
  assign in_word[1] = in_data_i.dist_east;
  assign in_word[2] = in_data_i.dist_north;
  assign in_word[3] = in_data_i.dist_west;
  assign in_word[4] = in_data_i.dist_south;
  assign in_word[5] = in_data_i.dist_northeast;
  assign in_word[6] = in_data_i.dist_northwest;
  assign in_word[7] = in_data_i.dist_southwest;
  assign in_word[8] = in_data_i.dist_southeast;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NUM_DIR; k++) begin
        f_q[k] <= W'(sat_to(66'(in_word[k]), W));
      end
      fdl_q[0] <= f_q;
      for (int i = 1; i < FDLY; i++) begin
        fdl_q[i] <= fdl_q[i-1];
      end
      rdl_q[0] <= rho_m;
      for (int i = 1; i < DIV_LAT; i++) begin
        rdl_q[i] <= rdl_q[i-1];
      end
      rout_q[0] <= rdl_q[DIV_LAT-1];
      for (int i = 1; i < LANE_LAT; i++) begin
        rout_q[i] <= rout_q[i-1];
      end
      velx_dl_q[0] <= velx;
      vely_dl_q[0] <= vely;
      for (int i = 1; i < LANE_LAT - 1; i++) begin
        velx_dl_q[i] <= velx_dl_q[i-1];
        vely_dl_q[i] <= vely_dl_q[i-1];
      end
      uv_q <= W'(sadd(64'(vx2), 64'(vy2), W));
    end
  end

  // ---- moments and velocity ----------------------------------------------
  lbm_moments #(.W(W)) u_moments (
    .clk_i, .en_i(en), .f_i(f_q), .rho_o(rho_m), .mx_o(mx_m), .my_o(my_m)
  );

  lbm_div #(.W(W), .F(F)) u_div_x (
    .clk_i, .en_i(en), .num_i(mx_m), .den_i(rho_m), .quot_o(vx)
  );
  lbm_div #(.W(W), .F(F)) u_div_y (
    .clk_i, .en_i(en), .num_i(my_m), .den_i(rho_m), .quot_o(vy)
  );

  lbm_mulq #(.W(W), .F(F)) u_velx (.clk_i, .en_i(en), .a_i(speed_q), .b_i(vx), .p_o(velx));
  lbm_mulq #(.W(W), .F(F)) u_vely (.clk_i, .en_i(en), .a_i(speed_q), .b_i(vy), .p_o(vely));
  lbm_mulq #(.W(W), .F(F)) u_vx2  (.clk_i, .en_i(en), .a_i(vx), .b_i(vx), .p_o(vx2));
  lbm_mulq #(.W(W), .F(F)) u_vy2  (.clk_i, .en_i(en), .a_i(vy), .b_i(vy), .p_o(vy2));

  // ---- direction lanes ----------------------------------------------------
  for (genvar k = 0; k < NUM_DIR; k++) begin : g_lane
    lbm_lane #(.W(W), .F(F), .K(k)) u_lane (
      .clk_i,
      .en_i         (en),
      .f_i          ($signed(fdl_q[FDLY-1][k])),
      .fo_i         ($signed(fdl_q[FDLY-1][DIR_OPP[k]])),
      .rho_i        (rdl_q[DIV_LAT-1]),
      .vx_i         (vx),
      .vy_i         (vy),
      .uv_i         (uv_q),
      .feq_opp_i    (feq[DIR_OPP[k]]),
      .relax_even_i (relax_even_q),
      .relax_odd_i  (relax_odd_q),
      .force_i      (force_q),
      .feq_o        (feq[k]),
      .post_o       (post[k])
    );
  end

  // ---- merge into the result register ------------------------------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q.post_rest      <= 32'(post[0]);
      out_data_q.post_east      <= 32'(post[1]);
      out_data_q.post_north     <= 32'(post[2]);
      out_data_q.post_west      <= 32'(post[3]);
      out_data_q.post_south     <= 32'(post[4]);
      out_data_q.post_northeast <= 32'(post[5]);
      out_data_q.post_northwest <= 32'(post[6]);
      out_data_q.post_southwest <= 32'(post[7]);
      out_data_q.post_southeast <= 32'(post[8]);
      out_data_q.density        <= 32'(rout_q[LANE_LAT-1]);
      out_data_q.vel_x          <= 32'(velx_dl_q[LANE_LAT-2]);
      out_data_q.vel_y          <= 32'(vely_dl_q[LANE_LAT-2]);
    end
  end

  // ---- assertions ---------------------------------------------------------
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted request did not enter the pipeline");

  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[NST-1]))
    else $error("result appeared without a request at the last stage");

  a_no_density_no_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.density <= 0) |->
      (out_data_o.vel_x == '0) && (out_data_o.vel_y == '0))
    else $error("nonzero velocity with nonpositive density");

endmodule

`default_nettype wire

// File: design/lbm_mulq.sv
// ----------------------------------------------------------------------------
// lbm_mulq - registered saturating fixed-point multiplier
// Sign-magnitude product, truncated toward zero by FRAC bits, clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module lbm_mulq #(
  parameter int W = 32,
  parameter int F = 24
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic signed [W-1:0] p_o
);

  localparam logic [2*W-1:0] LIM  = (2*W)'(1) << (W - 1);
  localparam logic [W-1:0]   SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   SMIN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]   ma, mb;
  logic [2*W-1:0] prod, shr;
  logic           neg;
  logic [W-1:0]   p_d;
  logic [W-1:0]   p_q;

  always_comb begin
    ma   = a_i[W-1] ? W'(-a_i) : W'(a_i);
    mb   = b_i[W-1] ? W'(-b_i) : W'(b_i);
    prod = (2*W)'(ma) * (2*W)'(mb);
    shr  = prod >> F;
    neg  = a_i[W-1] ^ b_i[W-1];
    if (!neg) begin
      p_d = (shr >= LIM) ? SMAX : shr[W-1:0];
    end else begin
      p_d = (shr > LIM) ? SMIN : W'(-shr[W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = $signed(p_q);

endmodule

`default_nettype wire

// File: design/lbm_moments.sv
// ----------------------------------------------------------------------------
// lbm_moments - density and first moments
// Saturating sums in direction order, split over two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module lbm_moments #(
  parameter int W = 32
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [lbm_pkg::NUM_DIR-1:0][W-1:0]   f_i,
  output logic signed [W-1:0]                  rho_o,
  output logic signed [W-1:0]                  mx_o,
  output logic signed [W-1:0]                  my_o
);
  import lbm_pkg::*;

  logic signed [W-1:0] rho_a_q, mx_a_q, my_a_q;
  logic signed [W-1:0] rho_a_d, mx_a_d, my_a_d;
  logic signed [W-1:0] f58_q [4];
  logic signed [W-1:0] rho_q, mx_q, my_q;
  logic signed [W-1:0] rho_d, mx_d, my_d;

  // directions 0..4
  always_comb begin
    wide_t r;
    r = 64'($signed(f_i[0]));
    for (int k = 1; k < 5; k++) begin
      r = sadd(r, 64'($signed(f_i[k])), W);
    end
    rho_a_d = W'(r);
    mx_a_d  = W'(ssub(64'($signed(f_i[1])), 64'($signed(f_i[3])), W));
    my_a_d  = W'(ssub(64'($signed(f_i[2])), 64'($signed(f_i[4])), W));
  end

  // diagonals 5..8
  always_comb begin
    wide_t r, x, y;
    r = 64'(rho_a_q);
    x = 64'(mx_a_q);
    y = 64'(my_a_q);
    for (int k = 0; k < 4; k++) begin
      r = sadd(r, 64'(f58_q[k]), W);
    end
    x = sadd(x, 64'(f58_q[0]), W);
    x = ssub(x, 64'(f58_q[1]), W);
    x = ssub(x, 64'(f58_q[2]), W);
    x = sadd(x, 64'(f58_q[3]), W);
    y = sadd(y, 64'(f58_q[0]), W);
    y = sadd(y, 64'(f58_q[1]), W);
    y = ssub(y, 64'(f58_q[2]), W);
    y = ssub(y, 64'(f58_q[3]), W);
    rho_d = W'(r);
    mx_d  = W'(x);
    my_d  = W'(y);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rho_a_q <= rho_a_d;
      mx_a_q  <= mx_a_d;
      my_a_q  <= my_a_d;
      for (int k = 0; k < 4; k++) begin
        f58_q[k] <= $signed(f_i[k+5]);
      end
      rho_q <= rho_d;
      mx_q  <= mx_d;
      my_q  <= my_d;
    end
  end

  assign rho_o = rho_q;
  assign mx_o  = mx_q;
  assign my_o  = my_q;

endmodule

`default_nettype wire

// File: design/lbm_div.sv
// ----------------------------------------------------------------------------
// lbm_div - pipelined fixed-point divider
// (num << F) / den, restoring, one quotient bit per stage; zero when the
// denominator is not positive, saturated on overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module lbm_div #(
  parameter int W = 32,
  parameter int F = 24
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] num_i,
  input  logic signed [W-1:0] den_i,
  output logic signed [W-1:0] quot_o
);

  localparam int NW = W + F;
  localparam int NS = W + 2;
  localparam logic [W:0]   LIM  = (W+1)'(1) << (W - 1);
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic [NW-1:0] nn_s  [NS];
  logic [W-1:0]  d_s   [NS];
  logic [W-1:0]  rem_s [NS];
  logic [W:0]    q_s   [NS];
  logic          neg_s [NS];
  logic          pos_s [NS];
  logic          ovf_s [NS];

  logic [W-1:0]  un, ud, r0;
  logic [NW-1:0] nn0;
  logic [W-1:0]  quot_d, quot_q;

  always_comb begin
    un  = num_i[W-1] ? W'(-num_i) : W'(num_i);
    ud  = den_i[W-1] ? W'(-den_i) : W'(den_i);
    nn0 = {un, {F{1'b0}}};
    r0  = W'(nn0 >> (W + 1));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nn_s[0]  <= nn0;
      d_s[0]   <= ud;
      rem_s[0] <= r0;
      q_s[0]   <= '0;
      neg_s[0] <= num_i[W-1] ^ den_i[W-1];
      pos_s[0] <= !den_i[W-1] && (den_i != '0);
      // full-width compare: the high part may be wider than a word
      ovf_s[0] <= (nn0 >> (W + 1)) >= NW'(ud);
      for (int j = 1; j < NS; j++) begin
        logic [W:0] t;
        t = {rem_s[j-1], nn_s[j-1][W+1-j]};
        if (t >= {1'b0, d_s[j-1]}) begin
          rem_s[j] <= W'(t - {1'b0, d_s[j-1]});
          q_s[j]   <= {q_s[j-1][W-1:0], 1'b1};
        end else begin
          rem_s[j] <= t[W-1:0];
          q_s[j]   <= {q_s[j-1][W-1:0], 1'b0};
        end
        nn_s[j]  <= nn_s[j-1];
        d_s[j]   <= d_s[j-1];
        neg_s[j] <= neg_s[j-1];
        pos_s[j] <= pos_s[j-1];
        ovf_s[j] <= ovf_s[j-1];
      end
      quot_q <= quot_d;
    end
  end

  always_comb begin
    logic [W:0] m;
    m = q_s[NS-1];
    if (!pos_s[NS-1]) begin
      quot_d = '0;
    end else if (!neg_s[NS-1]) begin
      quot_d = (ovf_s[NS-1] || m >= LIM) ? SMAX : m[W-1:0];
    end else begin
      quot_d = (ovf_s[NS-1] || m > LIM) ? SMIN : W'(-m[W-1:0]);
    end
  end

  assign quot_o = $signed(quot_q);

endmodule

`default_nettype wire

// File: design/lbm_lane.sv
// ----------------------------------------------------------------------------
// lbm_lane - one direction of the collision
// Equilibrium, TRT relaxation against the opposite lane and force term for
// a single D2Q9 direction. Ten register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module lbm_lane #(
  parameter int W = 32,
  parameter int F = 24,
  parameter int K = 0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] f_i,
  input  logic signed [W-1:0] fo_i,
  input  logic signed [W-1:0] rho_i,
  input  logic signed [W-1:0] vx_i,
  input  logic signed [W-1:0] vy_i,
  input  logic signed [W-1:0] uv_i,
  input  logic signed [W-1:0] feq_opp_i,
  input  logic signed [W-1:0] relax_even_i,
  input  logic signed [W-1:0] relax_odd_i,
  input  logic signed [W-1:0] force_i,
  output logic signed [W-1:0] feq_o,
  output logic signed [W-1:0] post_o
);
  import lbm_pkg::*;

  localparam int DX = DIR_X[K];
  localparam int DY = DIR_Y[K];
  localparam longint unsigned WNUM = (K == 0) ? 4 : 1;
  localparam longint unsigned WDEN = (K == 0) ? 9 : ((K < 5) ? 9 : 36);
  localparam longint unsigned WRAW = ((WNUM << (F + 1)) + WDEN) / (2 * WDEN);
  localparam logic signed [W-1:0] WGT = W'(sat_to(66'(WRAW), W));
  localparam logic signed [W-1:0] ONE = W'(sat_to(66'sd1 <<< F, W));

  logic signed [W-1:0] fd_q  [8];
  logic signed [W-1:0] fod_q [5];
  logic signed [W-1:0] rho1_q, rho2_q;
  logic signed [W-1:0] eu_d, eu_q, t3_q, e2_q, wr_q, wr4_q;
  logic signed [W-1:0] br1_q, c45_q, c15_q, br_q, feq_q;
  logic signed [W-1:0] sf_q, df_q, se_q, de_q, sym_q, anti_q;
  logic signed [W-1:0] pe_q, po_q, fk_q, po9_q, fk9_q, r1_q, post_q;
  logic signed [W-1:0] post_d;

  always_comb begin
    wide_t e;
    e = '0;
    if (DX > 0) begin
      e = sadd(e, 64'(vx_i), W);
    end else if (DX < 0) begin
      e = ssub(e, 64'(vx_i), W);
    end
    if (DY > 0) begin
      e = sadd(e, 64'(vy_i), W);
    end else if (DY < 0) begin
      e = ssub(e, 64'(vy_i), W);
    end
    eu_d = W'(e);
  end

  lbm_mulq #(.W(W), .F(F)) u_e2  (.clk_i, .en_i, .a_i(eu_q),  .b_i(eu_q),   .p_o(e2_q));
  lbm_mulq #(.W(W), .F(F)) u_wr  (.clk_i, .en_i, .a_i(WGT),   .b_i(rho2_q), .p_o(wr_q));
  lbm_mulq #(.W(W), .F(F)) u_feq (.clk_i, .en_i, .a_i(wr4_q), .b_i(br_q),   .p_o(feq_q));
  lbm_mulq #(.W(W), .F(F)) u_pe  (.clk_i, .en_i, .a_i(relax_even_i), .b_i(sym_q),
                                  .p_o(pe_q));
  lbm_mulq #(.W(W), .F(F)) u_po  (.clk_i, .en_i, .a_i(relax_odd_i), .b_i(anti_q),
                                  .p_o(po_q));
  lbm_mulq #(.W(W), .F(F)) u_fk  (.clk_i, .en_i, .a_i(WGT), .b_i(force_i), .p_o(fk_q));

  always_comb begin
    wide_t r;
    r = sadd(64'(r1_q), 64'(po9_q), W);
    if (DX > 0) begin
      r = sadd(r, 64'(fk9_q), W);
    end else if (DX < 0) begin
      r = ssub(r, 64'(fk9_q), W);
    end
    post_d = W'(r);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fd_q[0]  <= f_i;
      fod_q[0] <= fo_i;
      for (int i = 1; i < 8; i++) begin
        fd_q[i] <= fd_q[i-1];
      end
      for (int i = 1; i < 5; i++) begin
        fod_q[i] <= fod_q[i-1];
      end
      rho1_q <= rho_i;
      rho2_q <= rho1_q;
      // stage 1..2
      eu_q <= eu_d;
      t3_q <= W'(sat_to(66'(eu_q) * 66'sd3, W));
      // stage 3..4: bracket 1 + 3eu + 4.5eu^2 - 1.5uv
      br1_q <= W'(sadd(64'(ONE), 64'(t3_q), W));
      c45_q <= W'(scale_half(64'(e2_q), 9, W));
      c15_q <= W'(scale_half(64'(uv_i), 3, W));
      br_q  <= W'(ssub(sadd(64'(br1_q), 64'(c45_q), W), 64'(c15_q), W));
      wr4_q <= wr_q;
      // stage 6..7: even and odd parts against the opposite direction
      sf_q <= W'(sadd(64'(fd_q[4]), 64'(fod_q[4]), W));
      df_q <= W'(ssub(64'(fd_q[4]), 64'(fod_q[4]), W));
      se_q <= W'(sadd(64'(feq_q), 64'(feq_opp_i), W));
      de_q <= W'(ssub(64'(feq_q), 64'(feq_opp_i), W));
      sym_q  <= W'(ssub(half_tz(64'(sf_q)), half_tz(64'(se_q)), W));
      anti_q <= W'(ssub(half_tz(64'(df_q)), half_tz(64'(de_q)), W));
      // stage 9..10
      r1_q   <= W'(sadd(64'(fd_q[7]), 64'(pe_q), W));
      po9_q  <= po_q;
      fk9_q  <= fk_q;
      post_q <= post_d;
    end
  end

  assign feq_o  = feq_q;
  assign post_o = post_q;

endmodule

`default_nettype wire
